>>> rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants and controller/datapath interface types for the
// trial-division primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

   localparam int VALUE_BITS_DEF = 31;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;         // capture a new request
      logic init_div;     // set divisor to 3, square to 9
      logic div_start;    // clear remainder, reload dividend shifter
      logic div_step;     // one restoring-division bit
      logic advance;      // move to the next odd divisor
      logic finish;       // issue the response
      logic finish_prime; // verdict carried with finish
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic trivial;       // decided without any trial division
      logic trivial_prime; // verdict for the trivial case
      logic sq_over;       // divisor squared exceeds the candidate
      logic div_last;      // final division step is in progress
      logic rem_zero;      // remainder of the last division is zero
   } dp_status_type;

endpackage : ptd_pkg

`default_nettype wire

>>> rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer for the primality tester: screens trivial candidates, then walks
// odd divisors through the bound check and a bit-serial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl
   import ptd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCREEN = 5'b00010,
      ST_BOUND  = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_STEP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            if (status.trivial) begin
               cmd.finish       = 1'b1;
               cmd.finish_prime = status.trivial_prime;
               state_in         = ST_IDLE;
            end else begin
               cmd.init_div = 1'b1;
               state_in     = ST_BOUND;
            end
         end
         ST_BOUND: begin
            // no divisor up to the square root: prime
            if (status.sq_over) begin
               cmd.finish       = 1'b1;
               cmd.finish_prime = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.rem_zero) begin
               cmd.finish       = 1'b1;
               cmd.finish_prime = 1'b0;
               state_in         = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_BOUND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : ptd_ctrl

`default_nettype wire

>>> rtl/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// Candidate, odd divisor, running square of the divisor and a restoring
// bit-serial remainder unit; also holds the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_datapath
   import ptd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_BITS-1:0]  req_candidate,
   input  wire ctl_cmd_type            cmd,
   output dp_status_type               status,
   output logic                        rsp_valid,
   output logic [VALUE_BITS-1:0]       rsp_tested_value,
   output logic                        rsp_is_prime
);

   // divisor never exceeds sqrt(2^VALUE_BITS) + 2
   localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 2;
   localparam int SQ_BITS  = VALUE_BITS + 2;
   localparam int CNT_BITS = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [DIV_BITS-1:0]   d_ff, d_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [DIV_BITS-1:0]   r_ff, r_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic                  prime_ff, prime_in;

   logic [DIV_BITS:0]     r_shift;
   logic [DIV_BITS:0]     d_ext;
   logic [DIV_BITS:0]     r_sub;
   logic [DIV_BITS-1:0]   d_plus1;
   logic [SQ_BITS-1:0]    sq_inc;

   assign r_shift = {r_ff, shift_ff[VALUE_BITS-1]};
   assign d_ext   = {1'b0, d_ff};
   assign r_sub   = (r_shift >= d_ext) ? (r_shift - d_ext) : r_shift;
   assign d_plus1 = d_ff + DIV_BITS'(1);
   // (d+2)^2 = d^2 + 4(d+1)
   assign sq_inc  = SQ_BITS'({d_plus1, 2'b00});

   always_comb begin
      n_in     = n_ff;
      shift_in = shift_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      valid_in = cmd.finish;
      prime_in = prime_ff;
      if (cmd.load) begin
         n_in = req_candidate;
      end
      if (cmd.init_div) begin
         d_in  = DIV_BITS'(3);
         sq_in = SQ_BITS'(9);
      end
      if (cmd.div_start) begin
         shift_in = n_ff;
         r_in     = '0;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         r_in     = r_sub[DIV_BITS-1:0];
         cnt_in   = cnt_ff + CNT_BITS'(1);
      end
      if (cmd.advance) begin
         d_in  = d_ff + DIV_BITS'(2);
         sq_in = sq_ff + sq_inc;
      end
      if (cmd.finish) begin
         prime_in = cmd.finish_prime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      shift_ff <= shift_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
   end

   // candidates below 4 and even candidates need no trial division
   assign status.trivial       = (n_ff < VALUE_BITS'(4)) || !n_ff[0];
   assign status.trivial_prime = (n_ff[VALUE_BITS-1:1] == (VALUE_BITS-1)'(1));
   assign status.sq_over       = (sq_ff > SQ_BITS'(n_ff));
   assign status.div_last      = (cnt_ff == CNT_BITS'(VALUE_BITS - 1));
   assign status.rem_zero      = (r_ff == '0);

   assign rsp_valid        = valid_ff;
   assign rsp_tested_value = n_ff;
   assign rsp_is_prime     = prime_ff;

endmodule : ptd_datapath

`default_nettype wire

>>> rtl/prime_test_trial_division.sv
// ----------------------------------------------------------------------------
// prime_test_trial_division
// Trial-division primality test of one unsigned candidate per request.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  request   req_candidate                          start & !busy
//  response  rsp_tested_value, rsp_is_prime         rsp_valid, one cycle
//
//  Candidates below 4 and even candidates are decided in the screening state.
//  Each odd divisor d = 3, 5, ... with d*d <= candidate takes one bound check,
//  VALUE_BITS bit-serial remainder steps and one decision.
//  busy stays high from accept until the response is issued; the response
//  strobe is high in the first cycle with busy low and cannot be stalled.
//  Synchronous reset clears the controller and the response strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_trial_division
   import ptd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_BITS-1:0]  req_candidate,
   output logic                        rsp_valid,
   output logic [VALUE_BITS-1:0]       rsp_tested_value,
   output logic                        rsp_is_prime
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   ptd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ptd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_candidate    (req_candidate),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime)
   );

endmodule : prime_test_trial_division

`default_nettype wire

>>> sim/tb_prime_test_trial_division.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_test_trial_division
// Self-checking bench for the trial-division primality tester. A queue of
// directed and random candidates feeds a bursty request driver; a monitor
// compares every response strobe against an independent verdict computed
// when the request is accepted.
// ----------------------------------------------------------------------------

module tb_prime_test_trial_division;
   import ptd_pkg::*;

   localparam int VB = VALUE_BITS_DEF;

   typedef struct packed {
      logic [VB-1:0] value;
      logic          prime;
   } verdict_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic [VB-1:0] req_candidate = '0;
   logic          busy;
   logic          rsp_valid;
   logic [VB-1:0] rsp_tested_value;
   logic          rsp_is_prime;

   logic [VB-1:0] pending_candidates[$];
   verdict_type   verdicts_due[$];
   verdict_type   due;

   int            burst_left = 4;
   int            gap_left = 0;
   logic          fire;
   int            accepted = 0;
   int            responses = 0;
   int            primes_seen = 0;
   int            mismatches = 0;
   logic [VB-1:0] largest = '0;

   prime_test_trial_division dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_tested_value (rsp_tested_value),
      .rsp_is_prime     (rsp_is_prime)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Plain trial division over every divisor from 2 up to the square root.
   function automatic logic prime_verdict(input logic [VB-1:0] value);
      longint unsigned n;
      longint unsigned d;
      logic            verdict;
      n = value;
      verdict = (n >= 2);
      for (d = 2; verdict && d * d <= n; d++) begin
         if (n % d == 0) verdict = 1'b0;
      end
      return verdict;
   endfunction

   // Request driver: bursts of requests separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_candidate <= '0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            verdicts_due.push_back('{value: req_candidate,
                                     prime: prime_verdict(req_candidate)});
            accepted++;
            if (req_candidate > largest) largest = req_candidate;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
         // hold a request that is still waiting for the block
         if (start && !fire) begin
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_candidates.size() > 0) begin
            start <= 1'b1;
            req_candidate <= pending_candidates.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor: the block cannot be stalled, so take every strobe.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: value=%0d prime=%0b",
                        rsp_tested_value, rsp_is_prime);
         end else begin
            due = verdicts_due.pop_front();
            responses++;
            if (due.prime) primes_seen++;
            if (rsp_tested_value !== due.value || rsp_is_prime !== due.prime) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value=%0d prime=%0b, got value=%0d prime=%0b",
                           due.value, due.prime, rsp_tested_value, rsp_is_prime);
            end
         end
      end
   end

   initial begin
      int            kind;
      int            factor;
      logic [VB-1:0] v;

      // directed: below two, small primes, prime squares, bit patterns, extremes
      pending_candidates = '{
         31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd9, 31'd25, 31'd49,
         31'd121, 31'd15, 31'd91, 31'd97, 31'd7919, 31'd65537,
         31'd1042441,     // square of the prime 1021
         31'd1022117,     // 1009 * 1013, first factor found late
         31'h7FFFFFFE, 31'h40000000, 31'h3FFFFFFF, 31'h55555555,
         31'h2AAAAAAA, 31'h15555555,
         31'h7FFFFFFF     // all ones, prime: the slowest request
      };

      // random: mostly small values, some up to 2^20, larger ones only with small factors
      repeat (80) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            v = VB'($urandom_range(0, 4095));
         end else if (kind < 70) begin
            v = VB'($urandom);
            v[0] = 1'b0;
         end else if (kind < 90) begin
            v = VB'($urandom);
            factor = 3 + 2 * $urandom_range(0, 2);
            v = VB'(v - v % factor);
         end else if (kind < 95) begin
            v = VB'($urandom_range(4096, 1 << 20));
         end else begin
            v = VB'($urandom_range(0, 15));
         end
         pending_candidates.push_back(v);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_candidates.size() > 0 || start) @(posedge clock);
      while (verdicts_due.size() > 0) @(posedge clock);
      // drain: catch any stray response strobe
      repeat (50) @(posedge clock);

      $display("Covered %0d requests, %0d responses checked (%0d prime).",
               accepted, responses, primes_seen);
      $display("Largest candidate %0d, mismatches %0d.", largest, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("timeout with %0d responses still due", verdicts_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/ptd_pkg.sv
rtl/ptd_ctrl.sv
rtl/ptd_datapath.sv
rtl/prime_test_trial_division.sv
sim/tb_prime_test_trial_division.sv
